FILE: src/rkf_pkg.sv
// Package for the RK4 FitzHugh-Nagumo cell unit: Q4.28 types, register codes,
// reset values and the saturating fixed-point helpers.
// No dependencies; imported by all modules but rkf_checker.
`default_nettype none

package rkf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = 28;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned WideW   = 40;
  localparam int unsigned AccW    = 35;
  localparam int unsigned SixthW  = 27;

  typedef logic signed [DataW-1:0]   q_t;
  typedef logic signed [2*DataW-1:0] prod_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic signed [WideW-1:0]   wide_t;

  localparam logic [CfgIdxW-1:0] RegStepSize     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThresholdA   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStimCurrent  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRecoveryRate = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRecoveryGain = 3'd4;

  localparam q_t StepSizeRst     = 32'sd13421773;
  localparam q_t ThresholdARst   = 32'sd26843546;
  localparam q_t StimCurrentRst  = 32'sd0;
  localparam q_t RecoveryRateRst = 32'sd1342177;
  localparam q_t RecoveryGainRst = 32'sd536870912;

  localparam q_t QOne = 32'sd268435456;
  localparam q_t QMax = 32'sh7fffffff;
  localparam q_t QMin = 32'sh80000000;
  localparam logic signed [SixthW-1:0] QSixth = 27'sd44739243;

  typedef struct packed {
    q_t step_size;
    q_t threshold_a;
    q_t stim_current;
    q_t recovery_rate;
    q_t recovery_gain;
  } cfg_t;

  typedef struct packed {
    logic clip;
    q_t   val;
  } sq_t;

  typedef struct packed {
    q_t   v0;
    q_t   w0;
    acc_t acc_v;
    acc_t acc_w;
    logic last;
    logic clip;
  } ctx_t;

  function automatic sq_t sat_q(input wide_t x);
    sq_t r;
    logic [WideW-DataW:0] hi;
    hi = x[WideW-1:DataW-1];
    r.clip = !((&hi) || (~|hi));
    r.val = r.clip ? (x[WideW-1] ? QMin : QMax) : x[DataW-1:0];
    return r;
  endfunction

  function automatic sq_t add_q(input q_t a, input q_t b);
    return sat_q(WideW'(a) + WideW'(b));
  endfunction

  function automatic sq_t sub_q(input q_t a, input q_t b);
    return sat_q(WideW'(a) - WideW'(b));
  endfunction

  // Round half up at the Q4.28 point, then saturate.
  function automatic sq_t mul_round(input prod_t p);
    prod_t t;
    logic signed [2*DataW-FracW-1:0] r;
    t = p + (prod_t'(1) <<< (FracW - 1));
    r = t[2*DataW-1:FracW];
    return sat_q(WideW'(r));
  endfunction

  // Product with one half, rounded half up: floor((k + 1) / 2).
  function automatic q_t half_q(input q_t k);
    logic signed [DataW:0] t;
    t = {k[DataW-1], k} + (DataW+1)'(1);
    return t[DataW:1];
  endfunction

endpackage

`default_nettype wire

FILE: src/rkf_eval.sv
// Eight-stage pipeline that evaluates one RK4 slope pair k = h*(F, G) at a state.
// Carries the cell context alongside and folds in every saturation seen.
// Depends on rkf_pkg.
`default_nettype none

module rkf_eval (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rkf_pkg::q_t   v_i,
  input  rkf_pkg::q_t   w_i,
  input  rkf_pkg::ctx_t ctx_i,
  input  rkf_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output rkf_pkg::q_t   kv_o,
  output rkf_pkg::q_t   kw_o,
  output rkf_pkg::ctx_t ctx_o
);
  import rkf_pkg::*;

  localparam int unsigned Depth = 8;

  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] cl_q;
  ctx_t             ctx_q [Depth];

  q_t    v1_q, w1_q, da1_q, dm1_q;
  prod_t pg1_q;
  q_t    v2_q, w2_q, d2_q;
  prod_t p12_q;
  q_t    v3_q, w3_q, p13_q;
  prod_t pe3_q;
  q_t    w4_q, g4_q;
  prod_t p24_q;
  q_t    w5_q, p25_q;
  prod_t phw5_q;
  q_t    t6_q, kw6_q;
  prod_t phv7_q;
  q_t    kw7_q;
  q_t    kv8_q, kw8_q;

  sq_t da, dm, qg, dd, p1, gg, p2, t1, t2, kw, kv;
  logic [Depth-1:0] cl_d;

  always_comb begin
    da = sub_q(cfg_i.threshold_a, v_i);
    dm = sub_q(v_i, QOne);
    qg = mul_round(pg1_q);
    dd = sub_q(v1_q, qg.val);
    p1 = mul_round(p12_q);
    gg = mul_round(pe3_q);
    p2 = mul_round(p24_q);
    t1 = sub_q(p25_q, w5_q);
    t2 = add_q(t1.val, cfg_i.stim_current);
    kw = mul_round(phw5_q);
    kv = mul_round(phv7_q);

    cl_d[0] = ctx_i.clip | da.clip | dm.clip;
    cl_d[1] = cl_q[0] | qg.clip | dd.clip;
    cl_d[2] = cl_q[1] | p1.clip;
    cl_d[3] = cl_q[2] | gg.clip;
    cl_d[4] = cl_q[3] | p2.clip;
    cl_d[5] = cl_q[4] | t1.clip | t2.clip | kw.clip;
    cl_d[6] = cl_q[5];
    cl_d[7] = cl_q[6] | kv.clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cl_q     <= cl_d;
      ctx_q[0] <= ctx_i;
      for (int i = 1; i < Depth; i++) begin
        ctx_q[i] <= ctx_q[i-1];
      end

      v1_q   <= v_i;
      w1_q   <= w_i;
      da1_q  <= da.val;
      dm1_q  <= dm.val;
      pg1_q  <= prod_t'(cfg_i.recovery_gain) * prod_t'(w_i);

      v2_q   <= v1_q;
      w2_q   <= w1_q;
      p12_q  <= prod_t'(da1_q) * prod_t'(dm1_q);
      d2_q   <= dd.val;

      v3_q   <= v2_q;
      w3_q   <= w2_q;
      p13_q  <= p1.val;
      pe3_q  <= prod_t'(cfg_i.recovery_rate) * prod_t'(d2_q);

      w4_q   <= w3_q;
      p24_q  <= prod_t'(p13_q) * prod_t'(v3_q);
      g4_q   <= gg.val;

      w5_q   <= w4_q;
      p25_q  <= p2.val;
      phw5_q <= prod_t'(cfg_i.step_size) * prod_t'(g4_q);

      t6_q   <= t2.val;
      kw6_q  <= kw.val;

      phv7_q <= prod_t'(cfg_i.step_size) * prod_t'(t6_q);
      kw7_q  <= kw6_q;

      kv8_q  <= kv.val;
      kw8_q  <= kw7_q;
    end
  end

  always_comb begin
    ctx_o      = ctx_q[Depth-1];
    ctx_o.clip = cl_q[Depth-1];
  end

  assign valid_o = vld_q[Depth-1];
  assign kv_o    = kv8_q;
  assign kw_o    = kw8_q;

endmodule

`default_nettype wire

FILE: src/rkf_final.sv
// Three-stage tail of the RK4 step: adds k4 to the weighted slope sum,
// scales by one sixth and adds the start state with saturation. Depends on rkf_pkg.
`default_nettype none

module rkf_final (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rkf_pkg::q_t   kv_i,
  input  rkf_pkg::q_t   kw_i,
  input  rkf_pkg::ctx_t ctx_i,
  output logic          valid_o,
  output rkf_pkg::q_t   next_v_o,
  output rkf_pkg::q_t   next_w_o,
  output logic          last_o,
  output logic          clip_o
);
  import rkf_pkg::*;

  localparam int unsigned PW = AccW + SixthW;

  typedef logic signed [PW-1:0]       sprod_t;
  typedef logic signed [PW-FracW-1:0] sround_t;

  logic [2:0] vld_q;
  q_t     v0_1_q, w0_1_q, v0_2_q, w0_2_q;
  acc_t   sv1_q, sw1_q;
  sprod_t pv2_q, pw2_q;
  logic   last1_q, last2_q, clip1_q, clip2_q;
  q_t     nv3_q, nw3_q;
  logic   last3_q, clip3_q;

  sprod_t  tv, tw;
  sround_t rv, rw;
  sq_t     nv, nw;

  always_comb begin
    tv = pv2_q + (sprod_t'(1) <<< (FracW - 1));
    tw = pw2_q + (sprod_t'(1) <<< (FracW - 1));
    rv = tv[PW-1:FracW];
    rw = tw[PW-1:FracW];
    nv = sat_q(WideW'(v0_2_q) + WideW'(rv));
    nw = sat_q(WideW'(w0_2_q) + WideW'(rw));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv1_q   <= ctx_i.acc_v + acc_t'(kv_i);
      sw1_q   <= ctx_i.acc_w + acc_t'(kw_i);
      v0_1_q  <= ctx_i.v0;
      w0_1_q  <= ctx_i.w0;
      last1_q <= ctx_i.last;
      clip1_q <= ctx_i.clip;

      pv2_q   <= sprod_t'(sv1_q) * sprod_t'(QSixth);
      pw2_q   <= sprod_t'(sw1_q) * sprod_t'(QSixth);
      v0_2_q  <= v0_1_q;
      w0_2_q  <= w0_1_q;
      last2_q <= last1_q;
      clip2_q <= clip1_q;

      nv3_q   <= nv.val;
      nw3_q   <= nw.val;
      last3_q <= last2_q;
      clip3_q <= clip2_q | nv.clip | nw.clip;
    end
  end

  assign valid_o  = vld_q[2];
  assign next_v_o = nv3_q;
  assign next_w_o = nw3_q;
  assign last_o   = last3_q;
  assign clip_o   = clip3_q;

endmodule

`default_nettype wire

FILE: src/rk4_fitzhugh_nagumo_cell_unit.sv
// Top level of the RK4 FitzHugh-Nagumo cell unit: configuration registers, input
// stage, four slope pipelines, stage-state updates, tail and output skid register.
// Depends on rkf_pkg, rkf_eval and rkf_final.
//
// Usage: one cell (v, w, last marker) enters per input transaction and one result
// (next v, next w, last marker, saturation flag) leaves per output transaction,
// in order. The pipeline holds 39 register stages and sustains one cell per cycle
// unless the receiver stalls. The four slope evaluations of eight stages each,
// with a one-stage state update between them, set most of that depth; no stage
// has more than one multiply in any path. Configuration writes are taken in every
// cycle and act at once; the user must make them only while no cell is in flight,
// which the block does not enforce. Indexes past the last register are ignored.
// Reset clears all valid bits and loads the register defaults; results in flight
// are dropped. When the receiver stalls, the result at the pipeline's end moves
// into a skid register and in_ready_o falls in the next cycle; the whole pipeline
// then holds until that transaction completes, so nothing is lost or repeated.
`default_nettype none

module rk4_fitzhugh_nagumo_cell_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rkf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  rkf_pkg::q_t                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rkf_pkg::q_t                   cell_v_i,
  input  rkf_pkg::q_t                   cell_w_i,
  input  logic                          last_cell_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rkf_pkg::q_t                   next_v_o,
  output rkf_pkg::q_t                   next_w_o,
  output logic                          last_out_o,
  output logic                          saturated_o
);
  import rkf_pkg::*;

  localparam int unsigned NumEval = 4;
  localparam int unsigned NumPrep = NumEval - 1;

  typedef struct packed {
    q_t   v;
    q_t   w;
    ctx_t ctx;
  } stage_t;

  function automatic stage_t prep(input q_t kv, input q_t kw, input ctx_t c,
                                  input logic first, input logic full);
    stage_t s;
    sq_t    sv, sw;
    q_t     hv, hw;
    hv = full ? kv : half_q(kv);
    hw = full ? kw : half_q(kw);
    sv = add_q(c.v0, hv);
    sw = add_q(c.w0, hw);
    s.v = sv.val;
    s.w = sw.val;
    s.ctx = c;
    s.ctx.clip = c.clip | sv.clip | sw.clip;
    if (first) begin
      s.ctx.acc_v = acc_t'(kv);
      s.ctx.acc_w = acc_t'(kw);
    end else begin
      s.ctx.acc_v = c.acc_v + (acc_t'(kv) <<< 1);
      s.ctx.acc_w = c.acc_w + (acc_t'(kw) <<< 1);
    end
    return s;
  endfunction

  cfg_t cfg_q;
  logic pipe_en;

  logic in_vld_q;
  q_t   in_v_q, in_w_q;
  logic in_last_q;

  logic [NumEval-1:0] ev_vin, ev_vout;
  q_t   ev_v   [NumEval];
  q_t   ev_w   [NumEval];
  ctx_t ev_ctx [NumEval];
  q_t   ev_kv  [NumEval];
  q_t   ev_kw  [NumEval];
  ctx_t ev_cto [NumEval];

  logic [NumPrep-1:0] pr_vld_q;
  stage_t pr_q [NumPrep];
  stage_t pr_d [NumPrep];

  logic fin_vld, fin_last, fin_clip;
  q_t   fin_v, fin_w;

  logic skid_vld_q;
  q_t   skid_v_q, skid_w_q;
  logic skid_last_q, skid_clip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size     <= StepSizeRst;
      cfg_q.threshold_a   <= ThresholdARst;
      cfg_q.stim_current  <= StimCurrentRst;
      cfg_q.recovery_rate <= RecoveryRateRst;
      cfg_q.recovery_gain <= RecoveryGainRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStepSize:     cfg_q.step_size     <= cfg_data_i;
        RegThresholdA:   cfg_q.threshold_a   <= cfg_data_i;
        RegStimCurrent:  cfg_q.stim_current  <= cfg_data_i;
        RegRecoveryRate: cfg_q.recovery_rate <= cfg_data_i;
        RegRecoveryGain: cfg_q.recovery_gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pipe_en    = !skid_vld_q;
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pipe_en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      in_v_q    <= cell_v_i;
      in_w_q    <= cell_w_i;
      in_last_q <= last_cell_i;
    end
  end

  always_comb begin
    ev_vin[0]        = in_vld_q;
    ev_v[0]          = in_v_q;
    ev_w[0]          = in_w_q;
    ev_ctx[0].v0     = in_v_q;
    ev_ctx[0].w0     = in_w_q;
    ev_ctx[0].acc_v  = '0;
    ev_ctx[0].acc_w  = '0;
    ev_ctx[0].last   = in_last_q;
    ev_ctx[0].clip   = 1'b0;
    for (int i = 1; i < NumEval; i++) begin
      ev_vin[i] = pr_vld_q[i-1];
      ev_v[i]   = pr_q[i-1].v;
      ev_w[i]   = pr_q[i-1].w;
      ev_ctx[i] = pr_q[i-1].ctx;
    end
  end

  for (genvar g = 0; g < NumEval; g++) begin : g_eval
    rkf_eval u_eval (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (ev_vin[g]),
      .v_i     (ev_v[g]),
      .w_i     (ev_w[g]),
      .ctx_i   (ev_ctx[g]),
      .cfg_i   (cfg_q),
      .valid_o (ev_vout[g]),
      .kv_o    (ev_kv[g]),
      .kw_o    (ev_kw[g]),
      .ctx_o   (ev_cto[g])
    );
  end

  always_comb begin
    pr_d[0] = prep(ev_kv[0], ev_kw[0], ev_cto[0], 1'b1, 1'b0);
    pr_d[1] = prep(ev_kv[1], ev_kw[1], ev_cto[1], 1'b0, 1'b0);
    pr_d[2] = prep(ev_kv[2], ev_kw[2], ev_cto[2], 1'b0, 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= '0;
    end else if (pipe_en) begin
      pr_vld_q <= ev_vout[NumPrep-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < NumPrep; i++) begin
        pr_q[i] <= pr_d[i];
      end
    end
  end

  rkf_final u_final (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (ev_vout[NumEval-1]),
    .kv_i     (ev_kv[NumEval-1]),
    .kw_i     (ev_kw[NumEval-1]),
    .ctx_i    (ev_cto[NumEval-1]),
    .valid_o  (fin_vld),
    .next_v_o (fin_v),
    .next_w_o (fin_w),
    .last_o   (fin_last),
    .clip_o   (fin_clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_ready_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (fin_vld && !out_ready_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_v_q    <= fin_v;
      skid_w_q    <= fin_w;
      skid_last_q <= fin_last;
      skid_clip_q <= fin_clip;
    end
  end

  assign out_valid_o = skid_vld_q | fin_vld;
  assign next_v_o    = skid_vld_q ? skid_v_q    : fin_v;
  assign next_w_o    = skid_vld_q ? skid_w_q    : fin_w;
  assign last_out_o  = skid_vld_q ? skid_last_q : fin_last;
  assign saturated_o = skid_vld_q ? skid_clip_q : fin_clip;

endmodule

`default_nettype wire

FILE: src/rkf_checker.sv
// Port-level checks of the RK4 FitzHugh-Nagumo cell unit's flow control,
// with the bind statement that attaches them to the top level.
// Depends on rk4_fitzhugh_nagumo_cell_unit.
`default_nettype none

module rkf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] next_v_o,
  input logic [31:0] next_w_o,
  input logic        last_out_o,
  input logic        saturated_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_v_o) &&
    $stable(next_w_o) && $stable(last_out_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // Input is held off only while a result is waiting.
  a_hold_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no result pending");

  a_fall_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input ready dropped without an output stall");

  a_rise_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(out_valid_o && out_ready_i))
    else $error("input ready rose without a completed result transaction");

  // At the edge after reset is seen, the outputs show the cleared state.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("outputs active during reset");

endmodule

bind rk4_fitzhugh_nagumo_cell_unit rkf_checker u_rkf_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for rk4_fitzhugh_nagumo_cell_unit: drives cells and
// register writes over valid/ready channels and compares every result against an
// in-bench RK4 FitzHugh-Nagumo predictor. Depends on rkf_pkg and the RTL only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rkf_pkg::*;

  localparam longint QHalfL = 134217728;
  localparam longint SatHi  = 64'sd2147483647;
  localparam longint SatLo  = -64'sd2147483648;

  typedef struct {
    q_t   v;
    q_t   w;
    logic last;
    logic sat;
  } cell_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  q_t                 cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  q_t                 cell_v = '0;
  q_t                 cell_w = '0;
  logic               last_cell = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  q_t                 next_v;
  q_t                 next_w;
  logic               last_out;
  logic               saturated;

  cell_result_t expected_cells[$];
  int  errors = 0;
  int  idle_pct = 7;
  int  n_checked = 0;
  int  n_sat = 0;
  int  n_last = 0;
  int  n_writes = 0;

  longint step_h, thr_a, stim_i, rate_eps, gain_gamma;
  bit     step_clipped;

  rk4_fitzhugh_nagumo_cell_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .cell_v_i   (cell_v),
    .cell_w_i   (cell_w),
    .last_cell_i(last_cell),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .next_v_o   (next_v),
    .next_w_o   (next_w),
    .last_out_o (last_out),
    .saturated_o(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_cells.size());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint clamp_q(longint x);
    if (x > SatHi) begin
      step_clipped = 1'b1;
      return SatHi;
    end
    if (x < SatLo) begin
      step_clipped = 1'b1;
      return SatLo;
    end
    return x;
  endfunction

  function automatic longint round_q28(longint p);
    return (p + (longint'(1) <<< (FracW - 1))) >>> FracW;
  endfunction

  function automatic longint mul_q(longint x, longint y);
    return clamp_q(round_q28(x * y));
  endfunction

  function automatic longint excitation_rate(longint v, longint w);
    longint t;
    t = mul_q(clamp_q(thr_a - v), clamp_q(v - longint'(QOne)));
    t = mul_q(t, v);
    t = clamp_q(t - w);
    return clamp_q(t + stim_i);
  endfunction

  function automatic longint recovery_slope(longint v, longint w);
    return mul_q(rate_eps, clamp_q(v - mul_q(gain_gamma, w)));
  endfunction

  function automatic cell_result_t predict_cell(q_t v_in, q_t w_in, logic last);
    cell_result_t r;
    longint v, w, vs, ws, kv, kw, sum_v, sum_w;
    v = longint'(v_in);
    w = longint'(w_in);
    step_clipped = 1'b0;
    kv = mul_q(step_h, excitation_rate(v, w));
    kw = mul_q(step_h, recovery_slope(v, w));
    sum_v = kv;
    sum_w = kw;
    for (int s = 0; s < 3; s++) begin
      if (s < 2) begin
        vs = clamp_q(v + mul_q(QHalfL, kv));
        ws = clamp_q(w + mul_q(QHalfL, kw));
      end else begin
        vs = clamp_q(v + kv);
        ws = clamp_q(w + kw);
      end
      kv = mul_q(step_h, excitation_rate(vs, ws));
      kw = mul_q(step_h, recovery_slope(vs, ws));
      sum_v += (s < 2) ? 2 * kv : kv;
      sum_w += (s < 2) ? 2 * kw : kw;
    end
    vs = clamp_q(v + round_q28(sum_v * longint'(QSixth)));
    ws = clamp_q(w + round_q28(sum_w * longint'(QSixth)));
    r.v = vs[DataW-1:0];
    r.w = ws[DataW-1:0];
    r.last = last;
    r.sat = step_clipped;
    return r;
  endfunction

  function automatic void mirror_register_write(logic [CfgIdxW-1:0] idx, q_t data);
    case (idx)
      RegStepSize:     step_h = longint'(data);
      RegThresholdA:   thr_a = longint'(data);
      RegStimCurrent:  stim_i = longint'(data);
      RegRecoveryRate: rate_eps = longint'(data);
      RegRecoveryGain: gain_gamma = longint'(data);
      default: ;
    endcase
  endfunction

  task automatic report_field(string name, logic [DataW-1:0] exp_val, logic [DataW-1:0] got);
    if (got !== exp_val) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    cell_result_t exp_r;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        mirror_register_write(cfg_index, cfg_data);
        n_writes++;
      end
      if (in_valid && in_ready)
        expected_cells.push_back(predict_cell(cell_v, cell_w, last_cell));
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: result with none expected, expected none, actual %h %h",
                     $time, next_v, next_w);
        end else begin
          exp_r = expected_cells.pop_front();
          report_field("next_v", exp_r.v, next_v);
          report_field("next_w", exp_r.w, next_w);
          report_field("last_out", DataW'(exp_r.last), DataW'(last_out));
          report_field("saturated", DataW'(exp_r.sat), DataW'(saturated));
          n_checked++;
          if (exp_r.sat) n_sat++;
          if (exp_r.last) n_last++;
        end
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  task automatic send_cell(q_t v, q_t w, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_v <= v;
    cell_w <= w;
    last_cell <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_cells.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, q_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(q_t h, q_t a, q_t i, q_t eps, q_t gamma);
    write_reg(RegStepSize, h);
    write_reg(RegThresholdA, a);
    write_reg(RegStimCurrent, i);
    write_reg(RegRecoveryRate, eps);
    write_reg(RegRecoveryGain, gamma);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic q_t rand_between(longint lo, longint hi);
    return q_t'(lo + longint'($urandom_range(32'(hi - lo))));
  endfunction

  function automatic q_t rand_any();
    case ($urandom_range(7))
      0: return QMax;
      1: return QMin;
      2: return '0;
      default: return q_t'($urandom());
    endcase
  endfunction

  task automatic test_directed_cells();
    q_t vals[8];
    vals = '{'0, QOne, QMax, QMin, -32'sd1, 32'sd1, 32'sd26843546, -32'sd268435456};
    for (int k = 0; k < 8; k++)
      send_cell(vals[k], vals[(k + 3) % 8], k[0]);
    send_cell(QMax, QMax, 1'b1);
    send_cell(QMin, QMin, 1'b0);
    send_cell(QMax, QMin, 1'b1);
    send_cell(QMin, QMax, 1'b0);
    wait_results_done();
  endtask

  task automatic test_config_extremes();
    q_t settings[3];
    settings = '{QMax, QMin, '0};
    foreach (settings[s]) begin
      load_config(settings[s], settings[s], settings[s], settings[s], settings[s]);
      send_cell(QOne, -QOne, 1'b0);
      send_cell(QMax, QMin, 1'b1);
      send_cell(q_t'(32'sd134217728), q_t'(32'sd53687091), 1'b0);
      wait_results_done();
    end
    load_config(StepSizeRst, ThresholdARst, StimCurrentRst, RecoveryRateRst,
                RecoveryGainRst);
    for (int idx = RegRecoveryGain + 1; idx < (1 << CfgIdxW); idx++)
      write_reg(idx[CfgIdxW-1:0], rand_any());
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_cell(q_t'(32'sd134217728), '0, 1'b1);
    send_cell(QOne, q_t'(32'sd26843546), 1'b0);
    send_cell(-QOne, QOne, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_cells();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0)
        load_config(StepSizeRst, ThresholdARst, StimCurrentRst, RecoveryRateRst,
                    RecoveryGainRst);
      else if (phase[0])
        load_config(rand_between(0, 53687091), rand_between(0, 134217728),
                    rand_between(-53687091, 134217728), rand_between(0, 13421773),
                    rand_between(0, 1073741824));
      else
        load_config(rand_any(), rand_any(), rand_any(), rand_any(), rand_any());
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(99) < 80)
          send_cell(rand_between(-134217728, 402653184), rand_between(-134217728, 268435456),
                    ($urandom_range(15) == 0));
        else
          send_cell(rand_any(), rand_any(), 1'($urandom_range(1)));
        if (n == 100)
          wait_results_done();
      end
      wait_results_done();
    end
  endtask

  task automatic test_streaming();
    idle_pct = 0;
    for (int n = 0; n < 150; n++)
      send_cell(rand_between(-134217728, 402653184), rand_between(-134217728, 268435456),
                (n == 149));
    wait_results_done();
    idle_pct = 7;
  endtask

  initial begin
    step_h = longint'(StepSizeRst);
    thr_a = longint'(ThresholdARst);
    stim_i = longint'(StimCurrentRst);
    rate_eps = longint'(RecoveryRateRst);
    gain_gamma = longint'(RecoveryGainRst);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cells();
    test_config_extremes();
    test_random_cells();
    test_streaming();
    repeat (60) @(posedge clk);
    $display("Checked %0d cell updates over %0d register writes.", n_checked, n_writes);
    $display("%0d results saturated and %0d carried the last-cell marker.", n_sat, n_last);
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
